// ----- rtl/mgea_pkg.sv -----
// Package for the marker gated energy accumulator.
// Holds the trace mode and sequencer types, register indexes and the
// command and status structs shared by the controller and the datapath.
`timescale 1ns / 1ps
`default_nettype none

package mgea_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int REG_W      = 16;
	localparam int TRACE_W    = 16;
	localparam int COUNT_W    = 32;
	localparam int POWER_SHIFT = 24;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_LIMIT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DECIMATION     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MARKER_HIGH    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MARKER_LOW     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_POWER_SCALE    = 3'd4;

	localparam logic [REG_W-1:0] RST_DEBOUNCE_LIMIT = 16'd1;
	localparam logic [REG_W-1:0] RST_DECIMATION     = 16'd1;
	localparam logic [REG_W-1:0] RST_MARKER_HIGH    = 16'h2000;
	localparam logic [REG_W-1:0] RST_MARKER_LOW     = 16'hE000;
	localparam logic [REG_W-1:0] RST_POWER_SCALE    = 16'd4100;

	localparam logic EVT_START = 1'b0;
	localparam logic EVT_END   = 1'b1;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_START_SEEN,
		MODE_IN_TRACE,
		MODE_STOP_SEEN
	} mode_t;

	typedef enum logic {
		SEQ_IN,
		SEQ_STEP
	} seq_t;

	typedef struct packed {
		logic load;
		logic step;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic evt;
	} dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/mgea_ctrl.sv -----
// Sequencer for the marker gated energy accumulator.
// Takes an item, commits its step, and keeps the result valid flag.
// Depends on mgea_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mgea_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  wire                 m_tready,
	input  mgea_pkg::dp_status_t st,
	output mgea_pkg::dp_cmd_t   cmd
);
	import mgea_pkg::*;

	seq_t state_q;
	seq_t state_d;
	logic out_vld_q;
	logic commit;

	assign commit = (state_q == SEQ_STEP) && (!st.evt || !out_vld_q || m_tready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SEQ_IN: begin
				if (s_tvalid)
					state_d = SEQ_STEP;
			end
			SEQ_STEP: begin
				if (commit)
					state_d = SEQ_IN;
			end
			default: state_d = SEQ_IN;
		endcase
	end

	always_comb begin
		s_tready     = (state_q == SEQ_IN);
		cmd.load     = (state_q == SEQ_IN) && s_tvalid;
		cmd.step     = commit;
		cmd.out_load = commit && st.evt;
		m_tvalid     = out_vld_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= SEQ_IN;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_vld_q <= 1'b1;
			else if (m_tready)
				out_vld_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/mgea_dp.sv -----
// Datapath for the marker gated energy accumulator.
// Holds registers, trace mode, debounce and decimation counters, the
// two-stage power multiply and the saturating accumulator. Depends on mgea_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mgea_dp #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int ACC_WIDTH    = 56
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_wen,
	input  wire  [mgea_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  wire  [mgea_pkg::REG_W-1:0]           cfg_wdata,
	input  wire  signed [SAMPLE_WIDTH-1:0]       shunt_sample,
	input  wire  signed [SAMPLE_WIDTH-1:0]       supply_sample,
	input  wire  signed [SAMPLE_WIDTH-1:0]       marker_sample,
	input  mgea_pkg::dp_cmd_t                    cmd,
	output mgea_pkg::dp_status_t                 st,
	output logic                                 event_kind,
	output logic [mgea_pkg::TRACE_W-1:0]         trace_number,
	output logic [mgea_pkg::COUNT_W-1:0]         sample_index,
	output logic [mgea_pkg::COUNT_W-1:0]         counted_samples,
	output logic signed [ACC_WIDTH-1:0]          energy_sum
);
	import mgea_pkg::*;

	localparam int P1W  = 2 * SAMPLE_WIDTH;
	localparam int P2W  = P1W + REG_W + 1;
	localparam int PHW  = P2W - POWER_SHIFT;
	localparam int SUMW = ((ACC_WIDTH > PHW) ? ACC_WIDTH : PHW) + 1;
	localparam logic [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
	localparam logic [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

	logic [REG_W-1:0]        db_lim_q;
	logic [REG_W-1:0]        dec_q;
	logic signed [REG_W-1:0] hi_lvl_q;
	logic signed [REG_W-1:0] lo_lvl_q;
	logic [REG_W-1:0]        scale_q;

	mode_t                   mode_q;
	mode_t                   mode_d;
	logic [REG_W-1:0]        db_q;
	logic [REG_W-1:0]        db_d;
	logic [COUNT_W-1:0]      sample_q;
	logic [TRACE_W-1:0]      trace_q;
	logic [COUNT_W-1:0]      tsc_q;
	logic [COUNT_W-1:0]      tsc_d;
	logic [REG_W-1:0]        phase_q;
	logic [REG_W-1:0]        phase_d;
	logic signed [ACC_WIDTH-1:0] acc_q;
	logic                    acc_pend_q;

	logic signed [SAMPLE_WIDTH-1:0] marker_q;
	logic signed [P1W-1:0]   prod_s1;
	logic signed [P2W-1:0]   prod_s2;

	logic                    high;
	logic                    low;
	logic [REG_W:0]          db_next;
	logic                    db_hit;
	logic                    evt;
	logic                    kind;
	logic                    enter;
	logic                    trace_inc;
	logic                    acc_now;
	logic [REG_W-1:0]        phase_base;
	logic [COUNT_W-1:0]      tsc_base;
	logic [REG_W:0]          phase_next;
	logic [SUMW-1:0]         sum;
	logic [SUMW-ACC_WIDTH:0] sum_top;
	logic [ACC_WIDTH-1:0]    acc_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			db_lim_q <= RST_DEBOUNCE_LIMIT;
			dec_q    <= RST_DECIMATION;
			hi_lvl_q <= RST_MARKER_HIGH;
			lo_lvl_q <= RST_MARKER_LOW;
			scale_q  <= RST_POWER_SCALE;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				REG_DEBOUNCE_LIMIT: db_lim_q <= cfg_wdata;
				REG_DECIMATION:     dec_q    <= cfg_wdata;
				REG_MARKER_HIGH:    hi_lvl_q <= cfg_wdata;
				REG_MARKER_LOW:     lo_lvl_q <= cfg_wdata;
				REG_POWER_SCALE:    scale_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		high      = marker_q > hi_lvl_q;
		low       = marker_q < lo_lvl_q;
		db_next   = {1'b0, db_q} + 1'b1;
		db_hit    = db_next > {1'b0, db_lim_q};
		mode_d    = mode_q;
		db_d      = db_q;
		evt       = 1'b0;
		kind      = EVT_START;
		enter     = 1'b0;
		trace_inc = 1'b0;
		unique case (mode_q)
			MODE_IDLE: begin
				if (high) begin
					db_d = db_hit ? '0 : db_next[REG_W-1:0];
					if (db_hit)
						mode_d = MODE_START_SEEN;
				end
			end
			MODE_START_SEEN: begin
				if (low) begin
					mode_d = MODE_IN_TRACE;
					evt    = 1'b1;
					kind   = EVT_START;
					enter  = 1'b1;
					db_d   = '0;
				end
			end
			MODE_IN_TRACE: begin
				if (high) begin
					db_d = db_hit ? '0 : db_next[REG_W-1:0];
					if (db_hit) begin
						mode_d    = MODE_STOP_SEEN;
						evt       = 1'b1;
						kind      = EVT_END;
						trace_inc = 1'b1;
					end
				end
			end
			MODE_STOP_SEEN: begin
				if (low) begin
					mode_d = MODE_IDLE;
					db_d   = '0;
				end
			end
			default: mode_d = MODE_IDLE;
		endcase

		phase_base = enter ? '0 : phase_q;
		tsc_base   = enter ? '0 : tsc_q;
		acc_now    = (mode_d == MODE_IN_TRACE) && (phase_base == '0);
		phase_next = {1'b0, phase_base} + 1'b1;
		tsc_d      = tsc_base;
		phase_d    = phase_base;
		if (mode_d == MODE_IN_TRACE) begin
			if (acc_now && (tsc_base != '1))
				tsc_d = tsc_base + 1'b1;
			phase_d = (phase_next >= {1'b0, dec_q}) ? '0 : phase_next[REG_W-1:0];
		end
		st.evt = evt;
	end

	always_comb begin
		sum = SUMW'(acc_q) + SUMW'($signed(prod_s2[P2W-1:POWER_SHIFT]))
			+ SUMW'({1'b0, prod_s2[POWER_SHIFT-1]});
		sum_top = sum[SUMW-1:ACC_WIDTH-1];
		if ((&sum_top) || !(|sum_top))
			acc_sat = sum[ACC_WIDTH-1:0];
		else
			acc_sat = sum[SUMW-1] ? ACC_MIN : ACC_MAX;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			db_q       <= '0;
			sample_q   <= '0;
			trace_q    <= '0;
			tsc_q      <= '0;
			phase_q    <= '0;
			acc_q      <= '0;
			acc_pend_q <= 1'b0;
		end else begin
			acc_pend_q <= cmd.step && acc_now;
			if (cmd.step) begin
				mode_q   <= mode_d;
				db_q     <= db_d;
				sample_q <= sample_q + 1'b1;
				tsc_q    <= tsc_d;
				phase_q  <= phase_d;
				if (trace_inc)
					trace_q <= trace_q + 1'b1;
			end
			if (cmd.step && enter)
				acc_q <= '0;
			else if (acc_pend_q)
				acc_q <= acc_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			marker_q <= marker_sample;
			prod_s1  <= shunt_sample * supply_sample;
		end
		if (cmd.step)
			prod_s2 <= prod_s1 * $signed({1'b0, scale_q});
		if (cmd.out_load) begin
			event_kind   <= kind;
			trace_number <= trace_q;
			sample_index <= sample_q;
			if (kind == EVT_END) begin
				counted_samples <= tsc_q;
				energy_sum      <= acc_q;
			end else begin
				counted_samples <= '0;
				energy_sum      <= '0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/marker_gated_energy_accumulator.sv -----
// Top level of the marker gated energy accumulator.
// Packs the stream ports and joins mgea_ctrl and mgea_dp.
// Depends on mgea_pkg, mgea_ctrl and mgea_dp.
//
//   port group       dir  fields
//   s_tdata/tvalid   in   shunt_sample, supply_sample, marker_sample
//   m_tdata/tvalid   out  trace_number, sample_index, counted_samples, energy_sum
//   m_tuser          out  event_kind
//   cfg_*            in   register write: index, data
//
// Each item has a take cycle, which captures it and forms shunt times
// supply, and a step cycle, which steps the trace mode and multiplies by
// the power scale. The accumulate runs during the next item's take cycle.
// An item that makes a result stays in its step cycle while the previous
// result is still waiting on m_tready. Reset is asynchronous, active low.
`timescale 1ns / 1ps
`default_nettype none

module marker_gated_energy_accumulator #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int ACC_WIDTH    = 56
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_wen,
	input  wire  [mgea_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  wire  [mgea_pkg::REG_W-1:0]           cfg_wdata,
	input  wire                                  s_tvalid,
	output logic                                 s_tready,
	// shunt_sample, supply_sample, marker_sample
	input  wire  [((3*SAMPLE_WIDTH+7)/8)*8-1:0]  s_tdata,
	output logic                                 m_tvalid,
	input  wire                                  m_tready,
	// trace_number, sample_index, counted_samples, energy_sum
	output logic [((80+ACC_WIDTH+7)/8)*8-1:0]    m_tdata,
	// event_kind
	output logic                                 m_tuser
);
	import mgea_pkg::*;

	localparam int IN_W  = ((3*SAMPLE_WIDTH+7)/8)*8;
	localparam int OUT_W = ((80+ACC_WIDTH+7)/8)*8;
	localparam int OUT_USED = TRACE_W + 2*COUNT_W + ACC_WIDTH;

	dp_cmd_t    cmd;
	dp_status_t st;
	logic [TRACE_W-1:0]          trace_number;
	logic [COUNT_W-1:0]          sample_index;
	logic [COUNT_W-1:0]          counted_samples;
	logic signed [ACC_WIDTH-1:0] energy_sum;
	logic [IN_W-1:0]             in_bits;

	assign in_bits = s_tdata;

	mgea_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.st       (st),
		.cmd      (cmd)
	);

	mgea_dp #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.ACC_WIDTH    (ACC_WIDTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wen         (cfg_wen),
		.cfg_idx         (cfg_idx),
		.cfg_wdata       (cfg_wdata),
		.shunt_sample    ($signed(in_bits[SAMPLE_WIDTH-1:0])),
		.supply_sample   ($signed(in_bits[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH])),
		.marker_sample   ($signed(in_bits[3*SAMPLE_WIDTH-1:2*SAMPLE_WIDTH])),
		.cmd             (cmd),
		.st              (st),
		.event_kind      (m_tuser),
		.trace_number    (trace_number),
		.sample_index    (sample_index),
		.counted_samples (counted_samples),
		.energy_sum      (energy_sum)
	);

	assign m_tdata = OUT_W'({energy_sum, counted_samples, sample_index, trace_number}
		& {OUT_USED{1'b1}});

endmodule

`default_nettype wire

// ----- tb/sv/marker_gated_energy_accumulator_tb.sv -----
`timescale 1ns / 1ps
// Testbench for marker_gated_energy_accumulator: streams sample sets through the block,
// predicts every trace start and end event and checks each emitted event field by field.
// Depends on mgea_pkg and the marker_gated_energy_accumulator RTL.

module marker_gated_energy_accumulator_tb;
	import mgea_pkg::*;

	localparam int SW = 16;
	localparam int AW = 56;
	localparam int S_BITS = ((3*SW+7)/8)*8;
	localparam int M_BITS = ((80+AW+7)/8)*8;
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLDOFF_CYCLES = 600;

	typedef struct packed {
		logic          kind;
		logic [15:0]   trace;
		logic [31:0]   index;
		logic [31:0]   counted;
		logic [AW-1:0] energy;
	} trace_event_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [REG_W-1:0]     cfg_wdata = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_BITS-1:0]    s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_BITS-1:0]    m_tdata;
	logic                 m_tuser;

	// predicted block state and registers
	logic [15:0]        lim_r, decim_r, scale_r;
	logic signed [15:0] hi_r, lo_r;
	mode_t              mode_r;
	logic [15:0]        bounce_cnt, trace_cnt;
	logic [31:0]        sample_cnt, counted_cnt, phase_cnt;
	longint             energy_acc;

	trace_event_t      event_q[$];
	logic [S_BITS-1:0] sample_q[$];
	int                errors = 0;
	int                send_gap = 0;
	int                recv_gap = 0;
	logic              in_fire = 1'b0;
	logic              calm = 1'b0;
	logic              holdoff = 1'b0;

	marker_gated_energy_accumulator #(
		.SAMPLE_WIDTH(SW),
		.ACC_WIDTH(AW)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic bit bounce_done();
		int unsigned nxt;
		nxt = bounce_cnt + 1;
		if (nxt > lim_r) begin
			bounce_cnt = '0;
			return 1'b1;
		end
		bounce_cnt = nxt[15:0];
		return 1'b0;
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		$display("%0t mismatch on %s: expected %0h, got %0h", $time, what, want, got);
		errors++;
	endtask

	always @(posedge clk) begin
		logic signed [SW-1:0] shunt, supply, marker;
		logic                 high, low;
		longint               prod, pw, top, bottom;
		int unsigned          nxt;
		trace_event_t         want;
		in_fire <= s_tvalid && s_tready;
		if (!arst_n) begin
			lim_r = RST_DEBOUNCE_LIMIT;
			decim_r = RST_DECIMATION;
			hi_r = RST_MARKER_HIGH;
			lo_r = RST_MARKER_LOW;
			scale_r = RST_POWER_SCALE;
			mode_r = MODE_IDLE;
			bounce_cnt = '0;
			trace_cnt = '0;
			sample_cnt = '0;
			counted_cnt = '0;
			phase_cnt = '0;
			energy_acc = 0;
		end else begin
			if (cfg_wen) begin
				case (cfg_idx)
					REG_DEBOUNCE_LIMIT: lim_r = cfg_wdata;
					REG_DECIMATION:     decim_r = cfg_wdata;
					REG_MARKER_HIGH:    hi_r = cfg_wdata;
					REG_MARKER_LOW:     lo_r = cfg_wdata;
					REG_POWER_SCALE:    scale_r = cfg_wdata;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				shunt = s_tdata[SW-1:0];
				supply = s_tdata[2*SW-1:SW];
				marker = s_tdata[3*SW-1:2*SW];
				high = marker > hi_r;
				low = marker < lo_r;
				case (mode_r)
					MODE_IDLE: if (high && bounce_done())
						mode_r = MODE_START_SEEN;
					MODE_START_SEEN: if (low) begin
						mode_r = MODE_IN_TRACE;
						event_q.push_back('{EVT_START, trace_cnt, sample_cnt, 32'd0, '0});
						counted_cnt = '0;
						phase_cnt = '0;
						energy_acc = 0;
						bounce_cnt = '0;
					end
					MODE_IN_TRACE: if (high && bounce_done()) begin
						mode_r = MODE_STOP_SEEN;
						event_q.push_back('{EVT_END, trace_cnt, sample_cnt, counted_cnt,
							energy_acc[AW-1:0]});
						trace_cnt = trace_cnt + 16'd1;
					end
					default: if (low) begin
						mode_r = MODE_IDLE;
						bounce_cnt = '0;
					end
				endcase
				if (mode_r == MODE_IN_TRACE) begin
					if (phase_cnt == 0) begin
						prod = longint'(shunt) * longint'(supply) * longint'(scale_r);
						pw = (prod + (longint'(1) <<< (POWER_SHIFT - 1))) >>> POWER_SHIFT;
						top = (longint'(1) <<< (AW - 1)) - 1;
						bottom = -top - 1;
						if (pw > 0 && energy_acc > top - pw)
							energy_acc = top;
						else if (pw < 0 && energy_acc < bottom - pw)
							energy_acc = bottom;
						else
							energy_acc = energy_acc + pw;
						if (counted_cnt != '1)
							counted_cnt = counted_cnt + 32'd1;
					end
					nxt = phase_cnt + 1;
					phase_cnt = (nxt >= decim_r) ? 32'd0 : nxt;
				end
				sample_cnt = sample_cnt + 32'd1;
			end
			if (m_tvalid && m_tready) begin
				if (event_q.size() == 0) begin
					report_mismatch("unexpected event", 64'd0, 64'(m_tdata[47:16]));
				end else begin
					want = event_q.pop_front();
					if (m_tuser !== want.kind)
						report_mismatch("event_kind", 64'(want.kind), 64'(m_tuser));
					if (m_tdata[15:0] !== want.trace)
						report_mismatch("trace_number", 64'(want.trace),
							64'(m_tdata[15:0]));
					if (m_tdata[47:16] !== want.index)
						report_mismatch("sample_index", 64'(want.index),
							64'(m_tdata[47:16]));
					if (m_tdata[79:48] !== want.counted)
						report_mismatch("counted_samples", 64'(want.counted),
							64'(m_tdata[79:48]));
					if (m_tdata[80 +: AW] !== want.energy)
						report_mismatch("energy_sum", 64'(want.energy),
							64'(m_tdata[80 +: AW]));
				end
			end
		end
	end

	always @(negedge clk) begin
		if (!s_tvalid || in_fire) begin
			if (send_gap > 0) begin
				s_tvalid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (sample_q.size() > 0) begin
				s_tdata <= sample_q.pop_front();
				s_tvalid <= 1'b1;
				send_gap <= idle_len();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (holdoff) begin
			m_tready <= 1'b0;
		end else if (recv_gap > 0) begin
			m_tready <= 1'b0;
			recv_gap <= recv_gap - 1;
		end else begin
			m_tready <= 1'b1;
			recv_gap <= idle_len();
		end
	end

	initial begin
		wait (holdoff === 1'b1);
		repeat (HOLDOFF_CYCLES) @(negedge clk);
		holdoff <= 1'b0;
	end

	initial begin
		#4_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic logic [15:0] rand16();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] high_marker();
		return 16'(int'(hi_r) + 1 + int'($urandom_range(0, 32766 - int'(hi_r))));
	endfunction

	function automatic logic [15:0] low_marker();
		return 16'(-32768 + int'($urandom_range(0, int'(lo_r) + 32767)));
	endfunction

	function automatic logic [15:0] mid_marker();
		return 16'(int'(lo_r) + int'($urandom_range(0, int'(hi_r) - int'(lo_r))));
	endfunction

	task automatic push_sample(input logic [15:0] shunt, input logic [15:0] supply,
			input logic [15:0] marker);
		sample_q.push_back({marker, supply, shunt});
	endtask

	task automatic push_noise(input int n);
		repeat (n) sample_q.push_back(S_BITS'({$urandom, $urandom}));
	endtask

	task automatic push_trace(input int body);
		repeat (int'(lim_r) + 1) push_sample(rand16(), rand16(), high_marker());
		push_sample(rand16(), rand16(), low_marker());
		repeat (body)
			push_sample(rand16(), rand16(),
				($urandom_range(0, 19) == 0) ? high_marker() : mid_marker());
		repeat (int'(lim_r) + 1) push_sample(rand16(), rand16(), high_marker());
		push_sample(rand16(), rand16(), low_marker());
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
		cfg_wen <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(negedge clk);
	endtask

	task automatic apply_config(input logic [15:0] lim, input logic [15:0] dec,
			input logic [15:0] hi, input logic [15:0] lo, input logic [15:0] scale);
		write_reg(REG_DEBOUNCE_LIMIT, lim);
		write_reg(REG_DECIMATION, dec);
		write_reg(REG_MARKER_HIGH, hi);
		write_reg(REG_MARKER_LOW, lo);
		write_reg(REG_POWER_SCALE, scale);
		cfg_wen <= 1'b0;
	endtask

	// drain the stream, then let the pipeline settle before any register write
	task automatic run_phase();
		while (sample_q.size() != 0 || s_tvalid || event_q.size() != 0) begin
			@(negedge clk);
			#1;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		int random_items;
		int lim, dec, body;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset registers: field extremes and marker levels at the thresholds
		push_sample(16'h8000, 16'h8000, 16'h7fff);
		push_sample(16'h7fff, 16'h7fff, 16'h7fff);
		push_sample(16'h0000, 16'h0000, 16'h8000);
		push_sample(16'h8000, 16'h8000, 16'h2000);
		push_sample(16'h7fff, 16'h7fff, 16'he000);
		push_sample(16'h8000, 16'h7fff, 16'h0000);
		push_sample(16'h7fff, 16'h8000, 16'h0000);
		push_sample(16'hffff, 16'hffff, 16'h0000);
		push_sample(16'h0001, 16'hffff, 16'h0000);
		push_sample(16'h8000, 16'h8000, 16'h2001);
		push_sample(16'h8000, 16'h8000, 16'h7fff);
		push_sample(16'h0000, 16'h0000, 16'hdfff);
		run_phase();

		// zero debounce and zero decimation, rounding ties
		apply_config(16'd0, 16'd0, 16'h2000, 16'he000, 16'd4096);
		push_sample(16'h0000, 16'h0000, 16'h7fff);
		push_sample(16'h0000, 16'h0000, 16'h8000);
		push_sample(16'h0001, 16'h0800, 16'h0000);
		push_sample(16'hffff, 16'h0800, 16'h0000);
		push_sample(16'h0001, 16'h0801, 16'h0000);
		push_sample(16'h0000, 16'h0000, 16'h7fff);
		push_sample(16'h0000, 16'h0000, 16'h8000);
		run_phase();

		// writes beyond the register list
		for (int i = REG_POWER_SCALE + 1; i < 2**CFG_IDX_W; i++)
			write_reg(CFG_IDX_W'(i), REG_W'($urandom));
		cfg_wen <= 1'b0;
		@(negedge clk);

		// decimation lowered in the middle of a trace
		apply_config(16'd1, 16'd7, 16'h2000, 16'he000, 16'hffff);
		repeat (2) push_sample(rand16(), rand16(), high_marker());
		push_sample(rand16(), rand16(), low_marker());
		repeat (10) push_sample(rand16(), rand16(), mid_marker());
		run_phase();
		apply_config(16'd1, 16'd2, 16'h2000, 16'he000, 16'hffff);
		repeat (6) push_sample(rand16(), rand16(), mid_marker());
		repeat (2) push_sample(rand16(), rand16(), high_marker());
		push_sample(rand16(), rand16(), low_marker());
		run_phase();

		// register extremes, then low level above high level
		apply_config(16'hffff, 16'hffff, 16'h7fff, 16'h8000, 16'h0000);
		push_noise(30);
		run_phase();
		apply_config(16'h0000, 16'hffff, 16'h8000, 16'h7fff, 16'hffff);
		push_noise(40);
		run_phase();

		// receiver holds off while short traces keep coming
		apply_config(16'd0, 16'd1, 16'h2000, 16'he000, 16'd4100);
		calm <= 1'b1;
		repeat (10) push_trace(2);
		holdoff <= 1'b1;
		run_phase();

		random_items = 0;
		while (random_items < 1500) begin
			lim = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 4);
			dec = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 300) : $urandom_range(0, 9);
			apply_config(16'(lim), 16'(dec), 16'($urandom_range(0, 20000)),
				16'(-$urandom_range(1, 20000)), 16'($urandom));
			calm <= ($urandom_range(0, 4) == 0);
			repeat ($urandom_range(1, 4)) begin
				body = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) :
					$urandom_range(0, 30);
				if ($urandom_range(0, 6) == 0)
					push_noise($urandom_range(1, 20));
				else
					push_trace(body);
			end
			random_items += sample_q.size();
			run_phase();
		end

		if (errors == 0 && event_q.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/mgea_pkg.sv
rtl/mgea_ctrl.sv
rtl/mgea_dp.sv
rtl/marker_gated_energy_accumulator.sv
tb/sv/marker_gated_energy_accumulator_tb.sv
